// ===== hw/rtl/qph_pkg.sv =====
// Package for the quadratic probe hash table: widths, action and status codes,
// sequencer step codes and the control store. No dependencies.
package qph_pkg;

    // Slot count; a power of two, so that the home slot and probe wrap are masks.
    localparam int TABLE_SIZE = 16;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int KEY_W      = 31;
    localparam int ACT_W      = 2;
    localparam int STAT_W     = 2;
    localparam int SLOT_W     = 4;
    localparam int STEP_W     = 3;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

    localparam logic [STEP_W-1:0] S_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] S_PROBE = 3'd1;
    localparam logic [STEP_W-1:0] S_CHECK = 3'd2;
    localparam logic [STEP_W-1:0] S_READ  = 3'd3;
    localparam logic [STEP_W-1:0] S_RDCHK = 3'd4;
    localparam logic [STEP_W-1:0] S_DONE  = 3'd5;

    localparam logic [1:0] J_SEQ      = 2'd0;
    localparam logic [1:0] J_DISPATCH = 2'd1;
    localparam logic [1:0] J_LOOP     = 2'd2;
    localparam logic [1:0] J_WAIT     = 2'd3;

    typedef struct packed {
        logic              ready;
        logic              rd_probe;
        logic              rd_slot;
        logic              check;
        logic              rdchk;
        logic              ld_out;
        logic [1:0]        jump;
        logic [STEP_W-1:0] next;
    } ctrl_t;

    function automatic ctrl_t ucode(logic [STEP_W-1:0] step);
        ctrl_t c;
        c = '0;
        case (step)
            S_IDLE:
            begin
                c.ready = 1'b1;
                c.jump  = J_DISPATCH;
                c.next  = S_IDLE;
            end
            S_PROBE:
            begin
                c.rd_probe = 1'b1;
                c.jump     = J_SEQ;
                c.next     = S_CHECK;
            end
            S_CHECK:
            begin
                c.check = 1'b1;
                c.jump  = J_LOOP;
                c.next  = S_DONE;
            end
            S_READ:
            begin
                c.rd_slot = 1'b1;
                c.jump    = J_SEQ;
                c.next    = S_RDCHK;
            end
            S_RDCHK:
            begin
                c.rdchk = 1'b1;
                c.jump  = J_SEQ;
                c.next  = S_DONE;
            end
            S_DONE:
            begin
                c.ld_out = 1'b1;
                c.jump   = J_WAIT;
                c.next   = S_IDLE;
            end
            default:
            begin
                c.jump = J_SEQ;
                c.next = S_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/qph_if.sv =====
// Valid/ready channel interfaces for the hash table request and response items.
// Depends on qph_pkg.
interface qph_req_if import qph_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] read_slot;

    modport source (output valid, action, key, read_slot, input ready);
    modport sink   (input valid, action, key, read_slot, output ready);
endinterface

interface qph_rsp_if import qph_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_index;
    logic              slot_occupied;
    logic [KEY_W-1:0]  slot_key;

    modport source (output valid, status, slot_index, slot_occupied, slot_key, input ready);
    modport sink   (input valid, status, slot_index, slot_occupied, slot_key, output ready);
endinterface

// ===== hw/rtl/quadratic_probe_hash_table.sv =====
// Quadratic probe hash table: microcoded sequencer, key memory and occupancy flops.
// Depends on qph_pkg and the channel interfaces in qph_if.sv.
//
// Usage:
//   req carries one item per operation: action (insert, delete, read), key and
//   read_slot. rsp returns one item per request: status, slot_index,
//   slot_occupied and slot_key.
//   req.ready is high only while the sequencer sits in its idle step; one
//   operation is in flight at a time.
//   Insert and delete probe from the home slot (key mod TABLE_SIZE) along
//   home + i*i, one key memory read and one compare per probe, and stop on a
//   hit, a full table or a missing key. Read fetches the addressed slot and
//   checks its occupancy; an unused action code goes straight to the final step.
//   Reset clears every occupancy bit at once; no clearing pass follows, and
//   stored keys are only shown for occupied slots.
//   The result sits in an output register; a stall on rsp holds it there, and
//   the sequencer waits in its final step until the register frees up.
module quadratic_probe_hash_table import qph_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    qph_req_if.sink       req,
    qph_rsp_if.source     rsp
);

    logic [STEP_W-1:0]     step_reg, step_next;
    ctrl_t                 ctl;

    logic [ACT_W-1:0]      act_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [IDX_W-1:0]      rslot_reg;
    logic [IDX_W-1:0]      pos_reg, pos_next;
    logic [IDX_W-1:0]      inc_reg, inc_next;
    logic [IDX_W-1:0]      cnt_reg, cnt_next;

    logic [TABLE_SIZE-1:0] valid_reg, valid_next;
    logic [KEY_W-1:0]      keys_mem [TABLE_SIZE];
    logic [KEY_W-1:0]      rd_key_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic                  mem_we;

    logic [STAT_W-1:0]     res_status_reg, res_status_next;
    logic [SLOT_W-1:0]     res_index_reg, res_index_next;
    logic                  res_occ_reg, res_occ_next;
    logic [KEY_W-1:0]      res_key_reg, res_key_next;

    logic                  out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]     out_status_reg;
    logic [SLOT_W-1:0]     out_index_reg;
    logic                  out_occ_reg;
    logic [KEY_W-1:0]      out_key_reg;

    logic                  accept;
    logic                  hit;
    logic                  last_probe;
    logic                  out_free;
    logic                  ld_out;

    assign ctl        = ucode(step_reg);
    assign accept     = ctl.ready && req.valid;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign ld_out     = ctl.ld_out && out_free;
    assign last_probe = (cnt_reg == IDX_W'(TABLE_SIZE - 1));
    assign hit        = ((act_reg == ACT_INSERT) && !valid_reg[pos_reg])
                     || ((act_reg == ACT_DELETE) && valid_reg[pos_reg]
                         && (rd_key_reg == key_reg));
    assign mem_we     = ctl.check && (act_reg == ACT_INSERT) && !valid_reg[pos_reg];
    assign rd_addr    = ctl.rd_probe ? pos_reg : rslot_reg;

    assign req.ready         = ctl.ready;
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.slot_index    = out_index_reg;
    assign rsp.slot_occupied = out_occ_reg;
    assign rsp.slot_key      = out_key_reg;

    always_comb
    begin
        step_next = step_reg;
        case (ctl.jump)
            J_SEQ:
            begin
                step_next = ctl.next;
            end
            J_DISPATCH:
            begin
                if (accept)
                begin
                    if (req.action == ACT_INSERT || req.action == ACT_DELETE)
                    begin
                        step_next = S_PROBE;
                    end
                    else if (req.action == ACT_READ)
                    begin
                        step_next = S_READ;
                    end
                    else
                    begin
                        step_next = S_DONE;
                    end
                end
            end
            J_LOOP:
            begin
                step_next = (hit || last_probe) ? ctl.next : S_PROBE;
            end
            J_WAIT:
            begin
                if (out_free)
                begin
                    step_next = ctl.next;
                end
            end
            default:
            begin
                step_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pos_next        = pos_reg;
        inc_next        = inc_reg;
        cnt_next        = cnt_reg;
        valid_next      = valid_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_occ_next    = res_occ_reg;
        res_key_next    = res_key_reg;
        if (accept)
        begin
            pos_next        = req.key[IDX_W-1:0];
            inc_next        = IDX_W'(1);
            cnt_next        = '0;
            res_status_next = ST_DONE;
            res_index_next  = (req.action == ACT_READ) ? req.read_slot : '0;
            res_occ_next    = 1'b0;
            res_key_next    = '0;
        end
        if (ctl.check)
        begin
            if (hit)
            begin
                res_index_next = SLOT_W'(pos_reg);
                valid_next[pos_reg] = (act_reg == ACT_INSERT);
            end
            else if (last_probe)
            begin
                res_status_next = (act_reg == ACT_INSERT) ? ST_FULL : ST_NOTFOUND;
            end
            else
            begin
                // next probe: (i+1)^2 = i^2 + 2i + 1, wrap by mask
                pos_next = pos_reg + inc_reg;
                inc_next = inc_reg + IDX_W'(2);
                cnt_next = cnt_reg + IDX_W'(1);
            end
        end
        if (ctl.rdchk && valid_reg[rslot_reg])
        begin
            res_occ_next = 1'b1;
            res_key_next = rd_key_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ld_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            keys_mem[pos_reg] <= key_reg;
        end
        rd_key_reg <= keys_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= req.action;
            key_reg   <= req.key;
            rslot_reg <= IDX_W'(req.read_slot);
        end
        pos_reg        <= pos_next;
        inc_reg        <= inc_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_occ_reg    <= res_occ_next;
        res_key_reg    <= res_key_next;
        if (ld_out)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
            out_occ_reg    <= res_occ_reg;
            out_key_reg    <= res_key_reg;
        end
    end

`ifndef SYNTHESIS
    a_write_empty_only: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> valid_reg[$past(pos_reg)])
        else $error("key written without marking slot occupied");

    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ld_out && res_status_reg == ST_FULL) |-> valid_reg[key_reg[IDX_W-1:0]])
        else $error("table full reported with an empty home slot");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (step_reg != S_IDLE))
        else $error("sequencer stayed idle after accepting an item");

    a_one_slot_change: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.check |=> (valid_reg == $past(valid_reg)))
        else $error("occupancy changed outside a probe check");
`endif

endmodule

// ===== dv/qph_table_checker.sv =====
`timescale 1ns / 100ps
// Hash table checker: predicts every response from the accepted requests and compares it.
// Depends on qph_pkg and the channel interfaces in qph_if.sv.
module qph_table_checker import qph_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    qph_req_if   req,
    qph_rsp_if   rsp,
    output int   errors,
    output int   pending
);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot_index;
        logic              slot_occupied;
        logic [KEY_W-1:0]  slot_key;
    } table_rsp_t;

    logic [KEY_W-1:0]      slot_key_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] slot_full;
    table_rsp_t            expected_rsp_q [$];
    table_rsp_t            oldest_rsp;

    initial errors = 0;

    function automatic table_rsp_t probe_table_op(
        input logic [ACT_W-1:0]  act,
        input logic [KEY_W-1:0]  key,
        input logic [SLOT_W-1:0] rslot
    );
        table_rsp_t       r;
        logic [IDX_W-1:0] home;
        logic [IDX_W-1:0] p;
        bit               hit;
        r    = '0;
        hit  = 1'b0;
        home = key[IDX_W-1:0];
        case (act)
            ACT_INSERT:
            begin
                for (int i = 0; i < TABLE_SIZE && !hit; i++)
                begin
                    p = home + IDX_W'(i * i);
                    if (!slot_full[p])
                    begin
                        slot_full[p]    = 1'b1;
                        slot_key_mem[p] = key;
                        r.slot_index    = SLOT_W'(p);
                        hit             = 1'b1;
                    end
                end
                if (!hit)
                    r.status = ST_FULL;
            end
            ACT_DELETE:
            begin
                // empty slots on the way do not stop the search
                for (int i = 0; i < TABLE_SIZE && !hit; i++)
                begin
                    p = home + IDX_W'(i * i);
                    if (slot_full[p] && slot_key_mem[p] == key)
                    begin
                        slot_full[p] = 1'b0;
                        r.slot_index = SLOT_W'(p);
                        hit          = 1'b1;
                    end
                end
                if (!hit)
                    r.status = ST_NOTFOUND;
            end
            ACT_READ:
            begin
                r.slot_index = rslot;
                if (int'(rslot) < TABLE_SIZE && slot_full[rslot])
                begin
                    r.slot_occupied = 1'b1;
                    r.slot_key      = slot_key_mem[rslot];
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t ns: %s got %0h want %0h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_full    = '0;
            slot_key_mem = '{default: '0};
            expected_rsp_q.delete();
            pending <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_rsp_q.push_back(probe_table_op(req.action, req.key, req.read_slot));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsp_q.size() == 0)
                    note_mismatch("result with nothing pending, slot_index",
                                  32'(rsp.slot_index), '0);
                else
                begin
                    oldest_rsp = expected_rsp_q.pop_front();
                    if (rsp.status !== oldest_rsp.status)
                        note_mismatch("status", 32'(rsp.status), 32'(oldest_rsp.status));
                    if (rsp.slot_index !== oldest_rsp.slot_index)
                        note_mismatch("slot_index", 32'(rsp.slot_index),
                                      32'(oldest_rsp.slot_index));
                    if (rsp.slot_occupied !== oldest_rsp.slot_occupied)
                        note_mismatch("slot_occupied", 32'(rsp.slot_occupied),
                                      32'(oldest_rsp.slot_occupied));
                    if (rsp.slot_key !== oldest_rsp.slot_key)
                        note_mismatch("slot_key", 32'(rsp.slot_key), 32'(oldest_rsp.slot_key));
                end
            end
            pending <= expected_rsp_q.size();
        end
    end

endmodule

// ===== dv/quadratic_probe_hash_table_test.sv =====
`timescale 1ns / 100ps
// Top of the hash table test: clock, reset, request and response handshakes, verdict.
// Depends on qph_pkg, qph_if.sv, the table RTL and qph_table_checker.
module quadratic_probe_hash_table_test;
    import qph_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
    localparam int LIMIT        = 400000;
    localparam int LONG_STALL   = 300;
    localparam int PHASE_ITEMS  = 460;
    localparam int POOL         = 12;
    localparam int DRAIN_CYCLES = 40;

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count  = 0;
    int   tx_idle_pct  = 0;
    int   rx_idle_pct  = 0;
    int   stall_ticket = 0;
    int   fail_count;
    int   pending_count;

    logic [KEY_W-1:0] key_pool [POOL];

    qph_req_if req ();
    qph_rsp_if rsp ();

    quadratic_probe_hash_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    qph_table_checker table_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .errors  (fail_count),
        .pending (pending_count)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // response side: random back-pressure, plus one long hold when asked
    initial
    begin : rsp_ready_drive
        int hold;
        int seen;
        hold = 0;
        seen = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_ticket != seen)
            begin
                seen = stall_ticket;
                hold = LONG_STALL;
            end
            if (!rst_n)
                rsp.ready <= 1'b0;
            else if (hold > 0)
            begin
                hold = hold - 1;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_op(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] k,
                           input logic [SLOT_W-1:0] s);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.action    <= act;
        req.key       <= k;
        req.read_slot <= s;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic refresh_pool();
        for (int j = 0; j < POOL; j++)
        begin
            key_pool[j] = KEY_W'($urandom);
            // crowd a few home slots so probe chains get long and fill up
            if ($urandom_range(1))
                key_pool[j][IDX_W-1:0] = IDX_W'($urandom_range(2) * 7);
        end
        if ($urandom_range(3) == 0)
            key_pool[0] = '1;
        if ($urandom_range(3) == 0)
            key_pool[1] = '0;
    endtask

    task automatic send_random_op();
        int               pick;
        logic [KEY_W-1:0] k;
        pick = $urandom_range(99);
        k    = key_pool[$urandom_range(POOL - 1)];
        if (pick < 44)
            send_op(ACT_INSERT, k, SLOT_W'($urandom));
        else if (pick < 78)
            send_op(ACT_DELETE, k, SLOT_W'($urandom));
        else if (pick < 82)
            send_op(pick[0] ? ACT_INSERT : ACT_DELETE, KEY_W'($urandom), SLOT_W'($urandom));
        else if (pick < 95)
            send_op(ACT_READ, KEY_W'($urandom), SLOT_W'($urandom));
        else
            send_op(ACT_SPARE, KEY_W'($urandom), SLOT_W'($urandom));
    endtask

    task automatic wait_for_drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [KEY_W-1:0] top_key;
        top_key = '1;
        rst_n         <= 1'b0;
        req.valid     <= 1'b0;
        req.action    <= ACT_READ;
        req.key       <= '0;
        req.read_slot <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 17;
        rx_idle_pct <= 60;

        // one key per home slot writes every slot before anything reads one
        for (int h = 0; h < TABLE_SIZE; h++)
            send_op(ACT_INSERT,
                    h[0] ? {{(KEY_W - IDX_W){1'b1}}, IDX_W'(h)} : KEY_W'(h),
                    SLOT_W'(h));
        send_op(ACT_INSERT, top_key, '0);               // table full
        send_op(ACT_READ, '0, '0);
        send_op(ACT_READ, top_key, '1);
        send_op(ACT_DELETE, KEY_W'(21), '0);            // not found
        send_op(ACT_DELETE, '0, '0);
        send_op(ACT_READ, '0, '0);                      // emptied slot
        send_op(ACT_INSERT, top_key, '0);               // duplicate wraps to slot 0
        send_op(ACT_DELETE, top_key, '0);
        send_op(ACT_DELETE, top_key, '0);               // search passes an empty slot
        send_op(ACT_SPARE, top_key, '1);
        send_op(ACT_READ, '0, SLOT_W'(TABLE_SIZE - 1));

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_idle_pct = 17;
                    rx_idle_pct <= 60;
                    stall_ticket <= stall_ticket + 1;
                end
                1:
                begin
                    tx_idle_pct = 60;
                    rx_idle_pct <= 17;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 64 == 0)
                    refresh_pool();
                send_random_op();
            end
            wait_for_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
